/* src/dqe_pkg.sv */
// Package for the double-ended queue: data widths, operation codes and the
// result descriptor passed from the control unit to the output stage.
// No dependencies.
package dqe_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int COUNT_W      = 11;

    // Operation codes; codes 6 and 7 are unused and answer with an error
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    // Result of one operation, less the word that comes from the store
    typedef struct packed {
        logic                     use_rd;   // take the value from the store read
        logic                     error;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_res;

    localparam logic signed [DATA_W-1:0] VAL_ERR  = -32'sd1;
    localparam logic signed [DATA_W-1:0] VAL_ZERO = 32'sd0;

endpackage

/* src/dqe_ram.sv */
// Ring store of the queue: single-port synchronous memory, one read or one
// write per cycle, read data registered. Depends on dqe_pkg.
module dqe_ram
    import dqe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic                     i_rd_en,
    input  logic [IDX_W-1:0]         i_addr,
    input  logic signed [DATA_W-1:0] i_wdata,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dqe_ctrl.sv */
// Index and count unit of the queue: decodes an operation, moves the front
// and back indices, issues the store access and builds the result descriptor.
// Depends on dqe_pkg.
module dqe_ctrl
    import dqe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_wr_en,
    output logic                     o_rd_en,
    output logic [IDX_W-1:0]         o_addr,
    output logic signed [DATA_W-1:0] o_wdata,
    output t_res                     o_res
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] front_up, front_down, back_up, back_down;
    logic             empty, full;
    t_op              op;

    assign op    = t_op'(i_op);
    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_FULL);

    // Wrapping index steps: toward the front raises, toward the back lowers
    assign front_up   = (r_front == IDX_LAST) ? '0 : r_front + IDX_W'(1);
    assign front_down = (r_front == '0) ? IDX_LAST : r_front - IDX_W'(1);
    assign back_up    = (r_back == IDX_LAST) ? '0 : r_back + IDX_W'(1);
    assign back_down  = (r_back == '0) ? IDX_LAST : r_back - IDX_W'(1);

    // Operation decode
    always_comb begin
        n_front        = r_front;
        n_back         = r_back;
        n_count        = r_count;
        o_wr_en        = 1'b0;
        o_rd_en        = 1'b0;
        o_addr         = r_front;
        o_wdata        = i_value;
        o_res.use_rd   = 1'b0;
        o_res.error    = 1'b1;
        o_res.value    = VAL_ERR;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                o_res.value = VAL_ZERO;
                if (!full) begin
                    o_res.error = 1'b0;
                    o_wr_en     = i_accept;
                    n_count     = r_count + CNT_ONE;
                    if (empty) begin
                        n_back = r_front;
                        o_addr = r_front;
                    end else if (op == OP_PUSH_FRONT) begin
                        n_front = front_up;
                        o_addr  = front_up;
                    end else begin
                        n_back = back_down;
                        o_addr = back_down;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (!empty) begin
                    o_res.error  = 1'b0;
                    o_res.use_rd = 1'b1;
                    o_rd_en      = i_accept;
                    o_addr = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ? r_front : r_back;
                    if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
                        n_count = r_count - CNT_ONE;
                        if (r_count != CNT_ONE) begin
                            if (op == OP_POP_FRONT) begin
                                n_front = front_down;
                            end else begin
                                n_back = back_up;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_res.count    = COUNT_W'(n_count);
        o_res.is_empty = (n_count == '0);
    end

    // Index and count registers, moved once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    // A push into a non-full queue adds exactly one word
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !full
        |=> r_count == $past(r_count) + CNT_ONE)
        else $error("push did not grow the count");

    // A store write and a store read never go out together
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("store read and write in the same cycle");

    // The count never runs past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("count beyond capacity");

endmodule

/* src/double_ended_queue.sv */
// Top level of the bounded double-ended queue: control unit, ring store and
// a two-register output path. Depends on dqe_pkg, dqe_ctrl, dqe_ram.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_ready   i_op, i_value
//   result   out        o_valid / i_ready   o_result_value, o_error, o_count, o_is_empty
//
// One operation per cycle while the result is not stalled; an accepted beat passes through
// the middle stage (synchronous store read) and then the output register.
// Indices and count update at the accepting edge, so the next beat sees them at once.
// Synchronous active-low reset empties the queue; the store itself is not cleared.
// A stalled result holds the output; input is taken while the middle stage is empty or can move.
module double_ended_queue
    import dqe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_error,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    logic                     accept;
    logic                     wr_en, rd_en;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] wdata, rdata;
    t_res                     res;
    t_res                     r_s1;
    logic                     r_s1_valid;
    logic                     r_out_valid;
    logic                     s1_move;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_error;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_empty;

    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    dqe_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_wr_en  (wr_en),
        .o_rd_en  (rd_en),
        .o_addr   (addr),
        .o_wdata  (wdata),
        .o_res    (res)
    );

    dqe_ram #(.CAPACITY(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_rd_en (rd_en),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // Middle stage: holds the beat beside the registered store read word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
    end

    // Output register; the read word is merged in as the beat leaves the middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value <= r_s1.use_rd ? rdata : r_s1.value;
            r_out_error <= r_s1.error;
            r_out_count <= r_s1.count;
            r_out_empty <= r_s1.is_empty;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_error        = r_out_error;
    assign o_count        = r_out_count;
    assign o_is_empty     = r_out_empty;

    // A beat waiting in the middle stage is never dropped
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1))
        else $error("middle stage lost its beat");

    // Input is refused only when both stages are full and the result stalls
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_s1_valid && r_out_valid && !i_ready)
        else $error("input refused without a full pipeline");

    // The empty flag agrees with the count on every result
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

endmodule
